[rtl/vec3_axis_rotate_top_macros.svh]
// Assertion macros shared by the vec3_axis_rotate RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef VEC3_AXIS_ROTATE_TOP_MACROS_SVH
`define VEC3_AXIS_ROTATE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define VROT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VROT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VROT_ASSERT_SAME(label, ante, cons, msg)
`define VROT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/vrot_pkg.sv]
// Package for the 3D axis rotation block: sizes, codes, CORDIC angle table.
// No dependencies; used by every module of the block.
package vrot_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int TABLE_LEN     = 32;
    localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int DATA_W   = 32;
    localparam int ANGLE_W  = 16;
    localparam int MUL_IN_W = DATA_W + 1;
    localparam int GAIN_W   = FRAC_BITS + 1;
    localparam int PROD_W   = MUL_IN_W + GAIN_W + 1;
    localparam int PAIR_W   = DATA_W + FRAC_BITS + 4;
    localparam int ZACC_W   = DATA_W + 2;
    localparam int STAGE_W  = $clog2(TABLE_LEN);

    localparam logic [63:0] GAIN_Q32    = 64'd2608131496;
    localparam logic [63:0] GAIN_K_FULL =
        (GAIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [GAIN_W-1:0] GAIN_K = GAIN_K_FULL[GAIN_W-1:0];

    localparam logic [1:0] CMD_ROT_X = 2'd0;
    localparam logic [1:0] CMD_ROT_Y = 2'd1;
    localparam logic [1:0] CMD_ROT_Z = 2'd2;
    localparam logic [1:0] CMD_PASS  = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic signed [PAIR_W-1:0] a;
        logic signed [PAIR_W-1:0] b;
        logic signed [ZACC_W-1:0] zacc;
    } vrot_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_step(input logic [STAGE_W-1:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [PAIR_W-1:0] sext_pair(input logic signed [DATA_W-1:0] v);
        return {{(PAIR_W - DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

[rtl/vrot_if.sv]
// Valid/ready channel interfaces for point items in and rotated items out.
// No dependencies.
interface vrot_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        rotate_angle;

    modport source (output valid, cmd, coord_x, coord_y, coord_z, rotate_angle, input ready);
    modport sink   (input valid, cmd, coord_x, coord_y, coord_z, rotate_angle, output ready);
endinterface

interface vrot_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               clipped;

    modport source (output valid, out_x, out_y, out_z, clipped, input ready);
    modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

[rtl/vec3_axis_rotate_top.sv]
// Usage notes for vec3_axis_rotate_top.
// Input channel in_ch: cmd (0 rotate about X, 1 about Y, 2 about Z, 3 pass),
// a Q16.16 point and a 16-bit binary angle (65536 = one turn).
// Output channel out_ch: the rotated point, saturated to 32 bits, and a clipped
// flag set when either rotated coordinate hit a limit.
// Both channels move one item on a clock edge where valid and ready are high.
// The pipe has 2 front stages (pair select, gain multiply), one cell per CORDIC
// micro-rotation (16), and 1 output register, 19 registers in all.
// Throughput: one item per cycle while out_ch.ready is high; every stage holds
// its own item.
// Stalls: a stage takes a new item when it is empty or its successor moves, so
// a stalled receiver fills the pipe before in_ch.ready drops; bubbles collapse.
// Reset (rst_n low, asynchronous) empties all stages; nothing needs clearing.
// Depends on vrot_pkg, vrot_if, vrot_prep, vrot_cell, vrot_post.
module vec3_axis_rotate_top (
    input  logic       clk,
    input  logic       rst_n,
    vrot_in_if.sink    in_ch,
    vrot_out_if.source out_ch
);
    import vrot_pkg::*;

    vrot_item_t item_chain  [0:NUM_CELLS];
    logic       valid_chain [0:NUM_CELLS];
    logic       ready_chain [0:NUM_CELLS];

    vrot_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item       (item_chain[0]),
        .item_valid (valid_chain[0]),
        .item_ready (ready_chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        vrot_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_idx (STAGE_W'(g)),
            .in_item   (item_chain[g]),
            .in_valid  (valid_chain[g]),
            .in_ready  (ready_chain[g]),
            .out_item  (item_chain[g+1]),
            .out_valid (valid_chain[g+1]),
            .out_ready (ready_chain[g+1])
        );
    end

    vrot_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_chain[NUM_CELLS]),
        .item_valid (valid_chain[NUM_CELLS]),
        .item_ready (ready_chain[NUM_CELLS]),
        .out_ch     (out_ch)
    );

endmodule

[rtl/vrot_prep.sv]
// Front of the rotation pipe: pair select, half-turn pre-rotation, gain scaling.
// Depends on vrot_pkg and vrot_in_if.
module vrot_prep (
    input  logic                clk,
    input  logic                rst_n,
    vrot_in_if.sink             in_ch,
    output vrot_pkg::vrot_item_t item,
    output logic                item_valid,
    input  logic                item_ready
);
    import vrot_pkg::*;

    vrot_item_t sel_reg, sel_next;
    logic       sel_valid_reg;
    vrot_item_t scl_reg, scl_next;
    logic       scl_valid_reg;
    logic       en_sel, en_scl;

    logic                       flip;
    logic signed [PAIR_W-1:0]   pa, pb;
    logic [31:0]                acc;
    logic signed [PROD_W-1:0]   prod_a, prod_b;

    assign en_scl      = !scl_valid_reg || item_ready;
    assign en_sel      = !sel_valid_reg || en_scl;
    assign in_ch.ready = en_sel;

    always_comb
    begin
        flip = (in_ch.rotate_angle[15:14] == 2'd1) || (in_ch.rotate_angle[15:14] == 2'd2);
        unique case (in_ch.cmd)
            CMD_ROT_X:
            begin
                pa = sext_pair(in_ch.coord_y);
                pb = sext_pair(in_ch.coord_z);
            end
            CMD_ROT_Y:
            begin
                pa = sext_pair(in_ch.coord_x);
                pb = sext_pair(in_ch.coord_z);
            end
            default:
            begin
                pa = sext_pair(in_ch.coord_x);
                pb = sext_pair(in_ch.coord_y);
            end
        endcase
        // half turn added to the accumulator flips its top bit
        acc = {in_ch.rotate_angle[15] ^ flip, in_ch.rotate_angle[14:0], 16'd0};

        sel_next.cmd  = in_ch.cmd;
        sel_next.x    = in_ch.coord_x;
        sel_next.y    = in_ch.coord_y;
        sel_next.z    = in_ch.coord_z;
        sel_next.a    = flip ? -pa : pa;
        sel_next.b    = flip ? -pb : pb;
        sel_next.zacc = {{(ZACC_W - 32){acc[31]}}, acc};
    end

    always_comb
    begin
        prod_a = $signed(sel_reg.a[MUL_IN_W-1:0]) * $signed({1'b0, GAIN_K});
        prod_b = $signed(sel_reg.b[MUL_IN_W-1:0]) * $signed({1'b0, GAIN_K});
        scl_next   = sel_reg;
        scl_next.a = {{(PAIR_W - PROD_W){prod_a[PROD_W-1]}}, prod_a};
        scl_next.b = {{(PAIR_W - PROD_W){prod_b[PROD_W-1]}}, prod_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            scl_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_sel)
                sel_valid_reg <= in_ch.valid;
            if (en_scl)
                scl_valid_reg <= sel_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sel && in_ch.valid)
            sel_reg <= sel_next;
        if (en_scl && sel_valid_reg)
            scl_reg <= scl_next;
    end

    assign item       = scl_reg;
    assign item_valid = scl_valid_reg;

endmodule

[rtl/vrot_cell.sv]
// One CORDIC micro-rotation cell with its own pipeline register.
// Depends on vrot_pkg and the assertion macro header.
`include "vec3_axis_rotate_top_macros.svh"

module vrot_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [vrot_pkg::STAGE_W-1:0]  stage_idx,
    input  vrot_pkg::vrot_item_t          in_item,
    input  logic                          in_valid,
    output logic                          in_ready,
    output vrot_pkg::vrot_item_t          out_item,
    output logic                          out_valid,
    input  logic                          out_ready
);
    import vrot_pkg::*;

    vrot_item_t item_reg, item_next;
    logic       valid_reg;
    logic       en;

    logic signed [PAIR_W-1:0] sa, sb;
    logic signed [ZACC_W-1:0] step;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        sa   = in_item.a >>> stage_idx;
        sb   = in_item.b >>> stage_idx;
        step = {{(ZACC_W - 32){1'b0}}, atan_step(stage_idx)};
        item_next = in_item;
        // zero steers as positive
        if (!in_item.zacc[ZACC_W-1])
        begin
            item_next.a    = in_item.a - sb;
            item_next.b    = in_item.b + sa;
            item_next.zacc = in_item.zacc - step;
        end
        else
        begin
            item_next.a    = in_item.a + sb;
            item_next.b    = in_item.b - sa;
            item_next.zacc = in_item.zacc + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
            item_reg <= item_next;
    end

    assign out_item  = item_reg;
    assign out_valid = valid_reg;

    // residual angle stays well inside the accumulator
    `VROT_ASSERT_SAME(a_zacc_range, valid_reg,
        item_reg.zacc[ZACC_W-1] == item_reg.zacc[ZACC_W-2], "angle accumulator overflow")

endmodule

[rtl/vrot_post.sv]
// Back of the rotation pipe: rounding, saturation and the output register.
// Depends on vrot_pkg, vrot_out_if and the assertion macro header.
`include "vec3_axis_rotate_top_macros.svh"

module vrot_post (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vrot_pkg::vrot_item_t item,
    input  logic                 item_valid,
    output logic                 item_ready,
    vrot_out_if.source           out_ch
);
    import vrot_pkg::*;

    logic                     valid_reg;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] y_reg, y_next;
    logic signed [DATA_W-1:0] z_reg, z_next;
    logic                     clip_reg, clip_next;
    logic                     en, load;

    logic signed [DATA_W-1:0] ra, rb;
    logic                     ca, cb;

    localparam logic signed [PAIR_W-1:0] SAT_HI = sext_pair(32'sh7FFF_FFFF);
    localparam logic signed [PAIR_W-1:0] SAT_LO = sext_pair(32'sh8000_0000);

    function automatic logic signed [DATA_W-1:0] round_sat(
        input  logic signed [PAIR_W-1:0] v,
        output logic                     clip
    );
        logic signed [PAIR_W-1:0] r;
        logic signed [DATA_W-1:0] res;
        r = (v + (PAIR_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > SAT_HI)
        begin
            res  = SAT_HI[DATA_W-1:0];
            clip = 1'b1;
        end
        else if (r < SAT_LO)
        begin
            res  = SAT_LO[DATA_W-1:0];
            clip = 1'b1;
        end
        else
        begin
            res  = r[DATA_W-1:0];
            clip = 1'b0;
        end
        return res;
    endfunction

    assign en         = !valid_reg || out_ch.ready;
    assign item_ready = en;
    assign load       = en && item_valid;

    always_comb
    begin
        ra = round_sat(item.a, ca);
        rb = round_sat(item.b, cb);
        x_next    = item.x;
        y_next    = item.y;
        z_next    = item.z;
        clip_next = 1'b0;
        unique case (item.cmd)
            CMD_ROT_X:
            begin
                y_next    = ra;
                z_next    = rb;
                clip_next = ca | cb;
            end
            CMD_ROT_Y:
            begin
                x_next    = ra;
                z_next    = rb;
                clip_next = ca | cb;
            end
            CMD_ROT_Z:
            begin
                x_next    = ra;
                y_next    = rb;
                clip_next = ca | cb;
            end
            CMD_PASS:
            begin
                clip_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            clip_reg <= clip_next;
        end
    end

    assign out_ch.valid   = valid_reg;
    assign out_ch.out_x   = x_reg;
    assign out_ch.out_y   = y_reg;
    assign out_ch.out_z   = z_reg;
    assign out_ch.clipped = clip_reg;

    `VROT_ASSERT_NEXT(a_pass_exact, load && (item.cmd == CMD_PASS),
        !out_ch.clipped && (out_ch.out_x == $past(item.x)) && (out_ch.out_z == $past(item.z)),
        "pass-through item altered")
    `VROT_ASSERT_NEXT(a_x_axis_keeps_x, load && (item.cmd == CMD_ROT_X),
        out_ch.out_x == $past(item.x), "x changed by rotation about X")
    `VROT_ASSERT_NEXT(a_z_axis_keeps_z, load && (item.cmd == CMD_ROT_Z),
        out_ch.out_z == $past(item.z), "z changed by rotation about Z")

endmodule
